[hw/rtl/cwst_pkg.sv]
package cwst_pkg;

	localparam int unsigned PHASE_W   = 32;
	localparam int unsigned SAMPLE_W  = 16;
	localparam int unsigned MAG_W     = 15;
	localparam int unsigned VOL_W     = 7;
	localparam int unsigned STEP_W    = 31;
	localparam int unsigned HOLD_W    = 20;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_W     = 31;
	localparam int unsigned VOL_FULL_SCALE = 127;

	localparam logic [CFG_IDX_W-1:0] CFG_TONE_VOLUME       = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP        = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MUTE_HOLD_SAMPLES = 2'd2;

	localparam logic [VOL_W-1:0]  VOL_RESET       = 7'd64;
	localparam logic [STEP_W-1:0] STEP_RESET      = 31'd53687091;
	localparam logic [HOLD_W-1:0] HOLD_LEN_RESET  = 20'd96000;

	localparam logic REQ_TICK = 1'b0;
	localparam logic REQ_KEY  = 1'b1;

	localparam logic [63:0] Q30_TWO_PI        = 64'd6746518852;
	localparam logic [63:0] Q30_PI            = 64'd3373259426;
	localparam logic [63:0] Q30_HALF_PI       = 64'd1686629713;
	localparam logic [63:0] Q30_THREE_HALF_PI = 64'd5059889139;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_VOL,
		ST_MUL_RAMP,
		ST_MUL_RECIP,
		ST_MUL_DIV,
		ST_FIX
	} state_t;

	// sin(x) on [0, pi/2], q30 in and out, truncating taylor steps
	function automatic logic [63:0] quarter_sine_q30(input logic [63:0] x);
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] sum;
		x2   = (x * x) >> 30;
		term = x;
		sum  = x;
		term = ((term * x2) >> 30) / 64'd6;
		sum  = (sum >= term) ? sum - term : 64'd0;
		term = ((term * x2) >> 30) / 64'd20;
		sum  = sum + term;
		term = ((term * x2) >> 30) / 64'd42;
		sum  = (sum >= term) ? sum - term : 64'd0;
		term = ((term * x2) >> 30) / 64'd72;
		sum  = sum + term;
		term = ((term * x2) >> 30) / 64'd110;
		sum  = (sum >= term) ? sum - term : 64'd0;
		term = ((term * x2) >> 30) / 64'd156;
		sum  = sum + term;
		term = ((term * x2) >> 30) / 64'd210;
		sum  = (sum >= term) ? sum - term : 64'd0;
		return sum;
	endfunction

	// q15 sine of a q30 angle in [0, 2*pi)
	function automatic logic signed [SAMPLE_W-1:0] sine_q15_from_angle(input logic [63:0] u);
		logic [63:0] s;
		logic [63:0] q;
		logic        neg;
		logic [SAMPLE_W-1:0] mag;
		neg = 1'b0;
		if (u <= Q30_HALF_PI) begin
			s = quarter_sine_q30(u);
		end else if (u <= Q30_PI) begin
			s = quarter_sine_q30(Q30_PI - u);
		end else if (u <= Q30_THREE_HALF_PI) begin
			s = quarter_sine_q30(u - Q30_PI);
			neg = 1'b1;
		end else begin
			s = quarter_sine_q30((u >= Q30_TWO_PI) ? 64'd0 : Q30_TWO_PI - u);
			neg = 1'b1;
		end
		q = (s * 64'd32767 + (64'd1 << 29)) >> 30;
		if (q > 64'd32767) begin
			q = 64'd32767;
		end
		mag = q[SAMPLE_W-1:0];
		return neg ? -$signed(mag) : $signed(mag);
	endfunction

endpackage

[hw/rtl/cwst_sine_rom.sv]
module cwst_sine_rom #(
	parameter int unsigned DEPTH = 1024
) (
	input  logic                                  clk,
	input  logic [$clog2(DEPTH)-1:0]              addr,
	output logic signed [cwst_pkg::SAMPLE_W-1:0]  data
);
	import cwst_pkg::*;

	logic signed [SAMPLE_W-1:0] rom [DEPTH];

	for (genvar g = 0; g < DEPTH; g++) begin : g_entry
		localparam logic [63:0] Angle = (64'(g) * Q30_TWO_PI) / 64'(DEPTH);
		localparam logic signed [SAMPLE_W-1:0] Entry = sine_q15_from_angle(Angle);
		assign rom[g] = Entry;
	end

	always_ff @(posedge clk) begin
		data <= rom[addr];
	end

endmodule

[hw/rtl/cw_sidetone_generator.sv]
// a key update is taken in ST_IDLE and gives no result
// an audio sample steps through the volume, ramp, reciprocal and remainder
// products on the shared multiplier, then waits in ST_FIX for the output;
// no new request is taken until the state machine is back in ST_IDLE
// reset: arst_n clears key, ramp, hold count and phase, loads register defaults
module cw_sidetone_generator #(
	parameter int unsigned RAMP_STEPS       = 250,
	parameter int unsigned SINE_TABLE_DEPTH = 1024
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic [2*cwst_pkg::SAMPLE_W-1:0]       s_tdata,  // rx_left, rx_right
	input  logic [1:0]                            s_tuser,  // req_type, key_state
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [2*cwst_pkg::SAMPLE_W-1:0]       m_tdata,  // out_left, out_right
	output logic                                  m_tuser,  // rx_muted
	input  logic                                  cfg_wr_en,
	input  logic [cwst_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [cwst_pkg::CFG_W-1:0]            cfg_data
);
	import cwst_pkg::*;

	localparam int unsigned RampW  = $clog2(RAMP_STEPS + 1);
	localparam int unsigned AddrW  = $clog2(SINE_TABLE_DEPTH);
	localparam int unsigned Div    = VOL_FULL_SCALE * RAMP_STEPS;
	localparam int unsigned DivW   = $clog2(Div + 1);
	localparam longint unsigned RecipVal = (64'd1 << PHASE_W) / Div;
	localparam int unsigned RecipW = $clog2(RecipVal + 1);
	localparam int unsigned MulAW  = MAG_W + VOL_W + RampW;
	localparam int unsigned MulBW  = (RecipW > DivW) ? RecipW : DivW;
	localparam int unsigned ProdW  = MulAW + MulBW;
	localparam int unsigned QuoW   = MAG_W;

	state_t state_q, state_d;

	logic                    key_q;
	logic [RampW-1:0]        ramp_q;
	logic [HOLD_W-1:0]       hold_q;
	logic [PHASE_W-1:0]      phase_q;
	logic [VOL_W-1:0]        vol_q;
	logic [STEP_W-1:0]       step_q;
	logic [HOLD_W-1:0]       hold_len_q;
	logic                    out_valid_q;

	logic [SAMPLE_W-1:0]     rx_left_q, rx_right_q;
	logic                    muted_q;
	logic                    neg_q;
	logic [ProdW-1:0]        prod_q;
	logic [MulAW-1:0]        num_q;
	logic [QuoW-1:0]         quo_q;
	logic [2*SAMPLE_W-1:0]   out_data_q;
	logic                    out_muted_q;

	logic                    req_type, key_state, accept, done;
	logic [MulAW-1:0]        mul_a;
	logic [MulBW-1:0]        mul_b;
	logic signed [SAMPLE_W-1:0] rom_data;
	logic [SAMPLE_W-1:0]     sine_abs;
	logic [QuoW-1:0]         quo_est, quo_fix;
	logic [MulAW-1:0]        rem;
	logic [SAMPLE_W-1:0]     tone;

	assign req_type  = s_tuser[0];
	assign key_state = s_tuser[1];
	assign accept    = s_tvalid && s_tready;
	assign done      = (state_q == ST_FIX) && (!out_valid_q || m_tready);

	cwst_sine_rom #(
		.DEPTH(SINE_TABLE_DEPTH)
	) u_sine_rom (
		.clk (clk),
		.addr(phase_q[PHASE_W-1 -: AddrW]),
		.data(rom_data)
	);

	assign sine_abs = rom_data[SAMPLE_W-1] ? SAMPLE_W'(-rom_data) : SAMPLE_W'(rom_data);
	assign quo_est  = prod_q[PHASE_W +: QuoW];
	assign rem      = num_q - prod_q[MulAW-1:0];
	assign quo_fix  = quo_q + QuoW'(rem >= MulAW'(Div));
	assign tone     = neg_q ? -SAMPLE_W'(quo_fix) : SAMPLE_W'(quo_fix);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid && req_type == REQ_TICK) begin
					state_d = ST_MUL_VOL;
				end
			end
			ST_MUL_VOL:   state_d = ST_MUL_RAMP;
			ST_MUL_RAMP:  state_d = ST_MUL_RECIP;
			ST_MUL_RECIP: state_d = ST_MUL_DIV;
			ST_MUL_DIV:   state_d = ST_FIX;
			ST_FIX: begin
				if (!out_valid_q || m_tready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready = 1'b0;
		mul_a    = '0;
		mul_b    = '0;
		case (state_q)
			ST_IDLE: s_tready = 1'b1;
			ST_MUL_VOL: begin
				mul_a = MulAW'(sine_abs[MAG_W-1:0]);
				mul_b = MulBW'(vol_q);
			end
			ST_MUL_RAMP: begin
				mul_a = prod_q[MulAW-1:0];
				mul_b = MulBW'(ramp_q);
			end
			ST_MUL_RECIP: begin
				mul_a = prod_q[MulAW-1:0];
				mul_b = MulBW'(RecipVal);
			end
			ST_MUL_DIV: begin
				mul_a = MulAW'(quo_est);
				mul_b = MulBW'(Div);
			end
			// keep the remainder product while the result waits
			ST_FIX: begin
				mul_a = MulAW'(quo_q);
				mul_b = MulBW'(Div);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			key_q       <= 1'b0;
			ramp_q      <= '0;
			hold_q      <= '0;
			phase_q     <= '0;
			vol_q       <= VOL_RESET;
			step_q      <= STEP_RESET;
			hold_len_q  <= HOLD_LEN_RESET;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				case (cfg_index)
					CFG_TONE_VOLUME:       vol_q      <= cfg_data[VOL_W-1:0];
					CFG_PHASE_STEP:        step_q     <= cfg_data[STEP_W-1:0];
					CFG_MUTE_HOLD_SAMPLES: hold_len_q <= cfg_data[HOLD_W-1:0];
					default: ;
				endcase
			end
			if (accept) begin
				if (req_type == REQ_KEY) begin
					key_q <= key_state;
					if (key_state) begin
						hold_q <= hold_len_q;
					end
				end else begin
					if (key_q) begin
						if (ramp_q < RampW'(RAMP_STEPS)) begin
							ramp_q <= ramp_q + RampW'(1);
						end
					end else if (ramp_q != '0) begin
						ramp_q <= ramp_q - RampW'(1);
					end
					if (hold_q != '0) begin
						hold_q <= hold_q - HOLD_W'(1);
					end
				end
			end
			if (done) begin
				phase_q     <= phase_q + PHASE_W'(step_q);
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= ProdW'(mul_a) * ProdW'(mul_b);
		if (accept) begin
			rx_left_q  <= s_tdata[SAMPLE_W-1:0];
			rx_right_q <= s_tdata[2*SAMPLE_W-1:SAMPLE_W];
			muted_q    <= (hold_q != '0);
		end
		if (state_q == ST_MUL_VOL) begin
			neg_q <= rom_data[SAMPLE_W-1];
		end
		if (state_q == ST_MUL_RECIP) begin
			num_q <= prod_q[MulAW-1:0];
		end
		if (state_q == ST_MUL_DIV) begin
			quo_q <= quo_est;
		end
		if (done) begin
			out_muted_q <= muted_q;
			if (muted_q) begin
				out_data_q <= {tone, tone};
			end else begin
				out_data_q <= {rx_right_q, rx_left_q};
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_muted_q;

`ifndef SYNTHESIS
	a_ramp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ramp_q <= RampW'(RAMP_STEPS))
		else $error("ramp above limit");

	a_hold_dec: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req_type == REQ_TICK && hold_q != '0) |=> hold_q == $past(hold_q) - HOLD_W'(1))
		else $error("hold count not decremented");

	a_result_from_fix: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q) == ST_FIX)
		else $error("result without finished sample");

	a_muted_equal: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> m_tdata[SAMPLE_W-1:0] == m_tdata[2*SAMPLE_W-1:SAMPLE_W])
		else $error("sidetone channels differ");

	a_phase_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_FIX) |=> $stable(phase_q))
		else $error("phase moved outside sample end");
`endif

endmodule
